>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cbs_pkg.sv
// Shared types, constants and functions of the checksummed byte store.
package cbs_pkg;

    localparam int STORE_SIZE_DEF = 1024;
    localparam int ADDR_MAX_W     = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0]  ERASED_BYTE = 8'hFF;
    localparam logic [16:0] OFFSET_MAX  = 17'h1FFFF;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_BWRITE = 2'd2,
        REQ_BREAD  = 2'd3
    } req_t;

    // One classified request, as handed from the front to the back.
    typedef struct packed {
        req_t                  kind;
        logic                  addr_ok;
        logic [ADDR_MAX_W-1:0] addr_idx;
        logic [7:0]            data;
        logic                  first;
        logic                  last;
        logic                  csum_ok;
        logic [ADDR_MAX_W-1:0] csum_idx;
    } op_t;

    // Rotate left by one, then add the byte modulo 256.
    function automatic logic [7:0] sum_update(input logic [7:0] sum, input logic [7:0] b);
        logic [7:0] rot;
        rot = {sum[6:0], sum[7]};
        return rot + b;
    endfunction

endpackage

>>> rtl/checksummed_byte_store.sv
// Top level of the checksummed byte store.
//
// Requests come in on in_valid/in_stall: a transfer happens at a rising edge
// with in_valid high and in_stall low. Each request gives one result on
// out_valid/out_stall with read_data, checksum_ok and writes_done.
// Request kinds: single read, single write, block-write byte, block-read byte.
// Block bytes carry first_byte/last_byte marks; the last byte also stores or
// checks the running checksum in the byte just past the block.
// Each result is registered: the request goes through the queue, then the
// S_DATA state, to the output register; a block's last byte also passes
// S_CRD and S_CDATA. The back end takes a new request only once the last is
// done, as the store array has a single port (read, then compare and
// program in the next cycle). After reset the array is swept to 0xFF, one
// byte a cycle; in_stall stays high for the whole sweep.
// A two-entry queue sits between the front end and the back end, so up to
// two requests are taken while a result waits on out_stall; the result
// holds in its output register until transferred.
module checksummed_byte_store #(
    parameter int STORE_SIZE = cbs_pkg::STORE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] base_addr,
    input  logic [7:0]  data_in,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        checksum_ok,
    output logic [1:0]  writes_done
);

`include "assert_macros.svh"

    cbs_pkg::op_t push_op;
    cbs_pkg::op_t q_op;
    logic         accept;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    logic         clearing;

    assign in_stall = q_full || clearing;
    assign accept   = in_valid && !in_stall;

    cbs_front #(
        .STORE_SIZE (STORE_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .base_addr  (base_addr),
        .data_in    (data_in),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .op         (push_op)
    );

    cbs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .push_op (push_op),
        .pop     (q_pop),
        .full    (q_full),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    cbs_back #(
        .STORE_SIZE (STORE_SIZE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_op        (q_op),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .checksum_ok (checksum_ok),
        .writes_done (writes_done)
    );

    `ASSERT_IMPL(a_no_take_in_sweep, clk, rst_n, clearing, in_stall, "request taken during erase sweep")
    `ASSERT_IMPL(a_no_take_when_full, clk, rst_n, q_full, in_stall, "request taken into full queue")
    `ASSERT_IMPL(a_pop_needs_entry, clk, rst_n, q_pop, q_valid && !clearing, "pop of empty queue")
    `ASSERT_IMPL(a_writes_bound, clk, rst_n, out_valid, writes_done != 2'd3, "too many writes")

endmodule

>>> rtl/cbs_front.sv
// Front end: takes requests, tracks block position, resolves store addresses.
module cbs_front #(
    parameter int STORE_SIZE = cbs_pkg::STORE_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         req_type,
    input  logic [15:0]        base_addr,
    input  logic [7:0]         data_in,
    input  logic               first_byte,
    input  logic               last_byte,
    output cbs_pkg::op_t       op
);

    localparam logic [17:0] SIZE_LIM = 18'(STORE_SIZE);

    logic [15:0] base_reg, base_next;
    logic [16:0] off_reg, off_next;

    cbs_pkg::req_t kind;
    logic          is_block;
    logic [15:0]   base_use;
    logic [16:0]   off_use;
    logic [16:0]   off_adv;
    logic [17:0]   byte_addr;
    logic [17:0]   csum_addr;

    always_comb
    begin
        kind      = cbs_pkg::req_t'(req_type);
        is_block  = (kind == cbs_pkg::REQ_BWRITE) || (kind == cbs_pkg::REQ_BREAD);
        base_use  = first_byte ? base_addr : base_reg;
        off_use   = first_byte ? 17'd0 : off_reg;
        off_adv   = (off_use == cbs_pkg::OFFSET_MAX) ? off_use : off_use + 17'd1;
        byte_addr = is_block ? ({2'b00, base_use} + {1'b0, off_use}) : {2'b00, base_addr};
        csum_addr = {2'b00, base_use} + {1'b0, off_adv};

        op.kind     = kind;
        op.addr_ok  = byte_addr < SIZE_LIM;
        op.addr_idx = byte_addr[15:0];
        op.data     = data_in;
        op.first    = first_byte;
        op.last     = last_byte;
        op.csum_ok  = csum_addr < SIZE_LIM;
        op.csum_idx = csum_addr[15:0];

        base_next = base_reg;
        off_next  = off_reg;
        if (accept && is_block)
        begin
            base_next = base_use;
            off_next  = off_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            off_reg  <= '0;
        end
        else
        begin
            base_reg <= base_next;
            off_reg  <= off_next;
        end
    end

endmodule

>>> rtl/cbs_queue.sv
// Short queue of classified requests between the front and the back.
module cbs_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  cbs_pkg::op_t push_op,
    input  logic         pop,
    output logic         full,
    output logic         q_valid,
    output cbs_pkg::op_t q_op
);

    localparam int PTR_W = $clog2(cbs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cbs_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(cbs_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(cbs_pkg::QUEUE_DEPTH);

    cbs_pkg::op_t     entry_reg [cbs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        full    = (cnt_reg == CNT_FULL);
        q_valid = (cnt_reg != '0);
        q_op    = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_op;
    end

endmodule

>>> rtl/cbs_back.sv
// Back end: store array, erase sweep, read-compare-write and block checksum.
module cbs_back #(
    parameter int STORE_SIZE = cbs_pkg::STORE_SIZE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  cbs_pkg::op_t q_op,
    output logic         q_pop,
    output logic         clearing,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   read_data,
    output logic         checksum_ok,
    output logic [1:0]   writes_done
);

    localparam int ADDR_W = $clog2(STORE_SIZE);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_SIZE - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DATA,
        S_CRD,
        S_CDATA
    } state_t;

    state_t            state_reg;
    cbs_pkg::op_t      op_reg;
    logic [7:0]        sum_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              out_valid_reg;
    logic [7:0]        read_data_reg;
    logic              checksum_ok_reg;
    logic [1:0]        writes_done_reg;

    logic [7:0]        store_mem [STORE_SIZE];
    logic [7:0]        mem_rdata_reg;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [7:0]        mem_wdata;

    logic              start;
    logic              is_write;
    logic              is_block;
    logic              to_csum;
    logic [7:0]        rbyte;
    logic [7:0]        crbyte;
    logic [7:0]        sum_byte;
    logic [7:0]        sum_new;
    logic [ADDR_W-1:0] byte_idx;
    logic [ADDR_W-1:0] csum_idx;

    always_comb
    begin
        start    = q_valid && (!out_valid_reg || !out_stall);
        q_pop    = (state_reg == S_IDLE) && start;
        clearing = (state_reg == S_CLEAR);

        is_write = (op_reg.kind == cbs_pkg::REQ_WRITE) || (op_reg.kind == cbs_pkg::REQ_BWRITE);
        is_block = (op_reg.kind == cbs_pkg::REQ_BWRITE) || (op_reg.kind == cbs_pkg::REQ_BREAD);
        to_csum  = is_block && op_reg.last;

        rbyte    = op_reg.addr_ok ? mem_rdata_reg : cbs_pkg::ERASED_BYTE;
        crbyte   = op_reg.csum_ok ? mem_rdata_reg : cbs_pkg::ERASED_BYTE;
        sum_byte = (op_reg.kind == cbs_pkg::REQ_BWRITE) ? op_reg.data : rbyte;
        sum_new  = cbs_pkg::sum_update(op_reg.first ? 8'd0 : sum_reg, sum_byte);

        // out-of-range items never touch the array
        byte_idx = op_reg.addr_ok ? op_reg.addr_idx[ADDR_W-1:0] : '0;
        csum_idx = op_reg.csum_ok ? op_reg.csum_idx[ADDR_W-1:0] : '0;

        mem_addr  = '0;
        mem_we    = 1'b0;
        mem_wdata = op_reg.data;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_addr  = clr_cnt_reg;
                mem_we    = 1'b1;
                mem_wdata = cbs_pkg::ERASED_BYTE;
            end
            S_IDLE:
                mem_addr = q_op.addr_ok ? q_op.addr_idx[ADDR_W-1:0] : '0;
            S_DATA:
            begin
                mem_addr = byte_idx;
                // wear guard: program only on a change
                mem_we   = is_write && op_reg.addr_ok && (mem_rdata_reg != op_reg.data);
            end
            S_CRD:
                mem_addr = csum_idx;
            S_CDATA:
            begin
                mem_addr  = csum_idx;
                mem_wdata = sum_reg;
                mem_we    = (op_reg.kind == cbs_pkg::REQ_BWRITE) && op_reg.csum_ok
                            && (mem_rdata_reg != sum_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= store_mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            op_reg          <= '0;
            sum_reg         <= '0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            read_data_reg   <= '0;
            checksum_ok_reg <= 1'b0;
            writes_done_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_LAST)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        op_reg    <= q_op;
                        state_reg <= S_DATA;
                    end
                end
                S_DATA:
                begin
                    read_data_reg   <= is_write ? 8'd0 : rbyte;
                    checksum_ok_reg <= 1'b0;
                    writes_done_reg <= {1'b0, mem_we};
                    if (is_block)
                        sum_reg <= sum_new;
                    if (to_csum)
                        state_reg <= S_CRD;
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_CRD:
                    state_reg <= S_CDATA;
                S_CDATA:
                begin
                    checksum_ok_reg <= (op_reg.kind == cbs_pkg::REQ_BREAD) && (crbyte == sum_reg);
                    writes_done_reg <= writes_done_reg + {1'b0, mem_we};
                    out_valid_reg   <= 1'b1;
                    state_reg       <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign checksum_ok = checksum_ok_reg;
    assign writes_done = writes_done_reg;

endmodule
